// ===== design/assert_macros.svh =====
// ============================================================================
// Assertion macros
// Shared concurrent assertion shorthands for the span plotter checks.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion that is switched off while the synchronous reset is asserted.
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion that is checked at every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/awsp_pkg.sv =====
// ============================================================================
// awsp_pkg
// Types and fixed constants shared by the waveform span plotter modules.
// ============================================================================
package awsp_pkg;

    // Plot style codes.
    localparam logic [1:0] STYLE_DOT   = 2'd0;
    localparam logic [1:0] STYLE_LINE  = 2'd1;
    localparam logic [1:0] STYLE_SPIKE = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_PLOT_STYLE  = 2'd0;
    localparam logic [1:0] REG_ORIENTATION = 2'd1;
    localparam logic [1:0] REG_AMP_SHIFT   = 2'd2;

    // Configuration reset values.
    localparam logic [1:0] RST_PLOT_STYLE  = STYLE_LINE;
    localparam logic       RST_ORIENTATION = 1'b0;
    localparam logic [1:0] RST_AMP_SHIFT   = 2'd2;

    // Sample midpoint and the lift applied to horizontal dots.
    localparam logic [7:0] CENTER   = 8'd128;
    localparam int         DOT_LIFT = 20;

    // Configuration as seen by the span logic.
    typedef struct packed {
        logic [1:0] plot_style;
        logic       orientation;
        logic [1:0] amplitude_shift;
    } t_cfg;

    // One sample word with the previous level of its channel attached.
    typedef struct packed {
        logic       channel;
        logic [7:0] sample;
        logic [8:0] position;
        logic [7:0] prev;
    } t_item;

    // One span command.
    typedef struct packed {
        logic       span_axis;
        logic [8:0] fixed_coord;
        logic [8:0] span_start;
        logic [8:0] span_end;
        logic [7:0] color_index;
    } t_span;

endpackage

// ===== design/awsp_in_stage.sv =====
// ============================================================================
// awsp_in_stage
// Input register and per-channel previous-level store.
// ============================================================================
module awsp_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_channel,
    input  logic [7:0]        i_sample,
    input  logic [8:0]        i_position,
    input  logic              i_sweep_start,
    input  logic              i_adv,
    output logic              o_ready,
    output logic              o_valid,
    output awsp_pkg::t_item   o_item
);
    import awsp_pkg::*;

    logic       r_vld;
    t_item      r_item;
    logic [7:0] r_prev [2];
    logic       w_accept;
    logic [7:0] w_prev;

    // The register is free when empty or when its word moves on this cycle.
    assign o_ready  = !r_vld || i_adv;
    assign w_accept = i_valid && o_ready;

    // A sweep start restarts the trace from the midpoint.
    assign w_prev = i_sweep_start ? CENTER : r_prev[i_channel];

    // Valid flag and previous levels; every accepted word updates its channel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= 1'b0;
            r_prev[0] <= CENTER;
            r_prev[1] <= CENTER;
        end else begin
            if (w_accept) begin
                r_vld              <= 1'b1;
                r_prev[i_channel]  <= i_sample;
            end else if (i_adv) begin
                r_vld <= 1'b0;
            end
        end
    end

    // Payload register.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item.channel  <= i_channel;
            r_item.sample   <= i_sample;
            r_item.position <= i_position;
            r_item.prev     <= w_prev;
        end
    end

    assign o_valid = r_vld;
    assign o_item  = r_item;

endmodule

// ===== design/awsp_span_calc.sv =====
// ============================================================================
// awsp_span_calc
// Span geometry: amplitude scaling, wrap once, clamp and order of the ends.
// ============================================================================
module awsp_span_calc #(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 200,
    parameter int BASELINE_ROW  = 199
) (
    input  awsp_pkg::t_item i_item,
    input  awsp_pkg::t_cfg  i_cfg,
    output awsp_pkg::t_span o_span
);
    import awsp_pkg::*;

    // Signed working width that holds every intermediate coordinate.
    localparam int CW = $clog2(SCREEN_WIDTH + SCREEN_HEIGHT + BASELINE_ROW + 1024) + 1;

    typedef logic signed [CW-1:0] t_val;

    localparam t_val W_V     = CW'(SCREEN_WIDTH);
    localparam t_val H_V     = CW'(SCREEN_HEIGHT);
    localparam t_val B_V     = CW'(BASELINE_ROW);
    localparam t_val HALF_V  = CW'(SCREEN_WIDTH / 2);
    localparam t_val LIFT_V  = CW'(DOT_LIFT);
    localparam t_val W_MAX_V = CW'(SCREEN_WIDTH - 1);
    localparam t_val H_MAX_V = CW'(SCREEN_HEIGHT - 1);
    localparam t_val ONE_V   = CW'(1);

    function automatic t_val f_clamp(t_val v, t_val hi);
        t_val r;
        if (v < 0) begin
            r = '0;
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

    logic [7:0] w_a8, w_b8, w_dv, w_dp, w_color;
    t_val       w_a, w_b, w_pos, w_col, w_row;
    t_val       w_ea, w_eb, w_size, w_fixed;
    t_val       w_wa, w_wb, w_ca, w_cb;
    logic       w_axis, w_wrap;

    // Scaled levels and distances from the midpoint.
    always_comb begin
        w_a8 = i_item.sample >> i_cfg.amplitude_shift;
        w_b8 = i_item.prev >> i_cfg.amplitude_shift;
        w_a  = CW'(w_a8);
        w_b  = CW'(w_b8);
        w_dv = i_item.sample[7] ? (i_item.sample - CENTER) : (CENTER - i_item.sample);
        w_dp = i_item.prev[7] ? (i_item.prev - CENTER) : (CENTER - i_item.prev);
    end

    // Sweep coordinates: the right channel sits half a screen further along.
    always_comb begin
        w_pos = CW'(i_item.position);
        w_col = f_clamp(i_item.channel ? ((w_pos + W_V) >>> 1) : (w_pos >>> 1), W_MAX_V);
        w_row = f_clamp(w_pos, H_MAX_V);
    end

    // Select the two raw ends and the screen size for the active style.
    always_comb begin
        w_axis  = 1'b0;
        w_fixed = w_col;
        w_size  = H_V;
        w_wrap  = 1'b1;
        w_color = i_item.sample;
        w_ea    = B_V - w_a;
        w_eb    = B_V - w_b;
        unique case (i_cfg.plot_style)
            STYLE_SPIKE: begin
                w_ea    = B_V - CW'(w_dv);
                w_eb    = B_V - CW'(w_dp);
                w_color = w_dv;
            end
            STYLE_DOT: begin
                w_wrap = 1'b0;
                if (i_cfg.orientation) begin
                    w_axis  = 1'b1;
                    w_fixed = w_row;
                    w_size  = W_V;
                    w_ea    = i_item.channel ? (HALF_V + w_a) : (HALF_V - w_a);
                end else begin
                    w_ea = B_V - w_a - LIFT_V;
                end
                w_eb = w_ea;
            end
            default: begin
                // Connected line; the unused code behaves the same.
                if (i_cfg.orientation) begin
                    w_axis  = 1'b1;
                    w_fixed = w_row;
                    w_size  = W_V;
                    w_ea    = i_item.channel ? (HALF_V + w_a) : (HALF_V - w_a);
                    w_eb    = i_item.channel ? (HALF_V + w_b) : (HALF_V - w_b);
                end
            end
        endcase
    end

    // Wrap once, except for dots, when both ends fall off the same side, then clamp.
    always_comb begin
        w_wa = w_ea;
        w_wb = w_eb;
        if (w_wrap && (w_wa >= w_size) && (w_wb >= w_size)) begin
            w_wa = w_wa - w_size;
            w_wb = w_wb - w_size;
        end
        if (w_wrap && (w_wa < 0) && (w_wb < 0)) begin
            w_wa = w_wa + w_size;
            w_wb = w_wb + w_size;
        end
        w_ca = f_clamp(w_wa, w_size - ONE_V);
        w_cb = f_clamp(w_wb, w_size - ONE_V);
    end

    // Order the ends and trim to the command fields.
    always_comb begin
        o_span.span_axis   = w_axis;
        o_span.fixed_coord = w_fixed[8:0];
        o_span.span_start  = (w_ca < w_cb) ? w_ca[8:0] : w_cb[8:0];
        o_span.span_end    = (w_ca < w_cb) ? w_cb[8:0] : w_ca[8:0];
        o_span.color_index = w_color;
    end

endmodule

// ===== design/audio_waveform_span_plotter_core.sv =====
// ============================================================================
// audio_waveform_span_plotter_core
// Turns stereo audio samples into span commands for a waveform display.
// ============================================================================
// Usage:
// Sample words enter on i_in_valid / o_in_ready with channel, sample,
// sweep position and sweep-start flag. Each word yields one span command
// on o_out_valid / i_out_ready: axis, fixed coordinate, ordered ends and
// a palette index. Style, orientation and amplitude shift are written
// through i_cfg_wr_en / i_cfg_idx / i_cfg_data; the user must do so only
// while the block is idle, which is not enforced. A word accepted is
// registered with its channel's previous level in the input register,
// then its command in the output register. Throughput is one word per
// cycle while the receiver keeps up, set by the two-register pipeline.
// Reset clears both valid flags, restores the default configuration and
// sets both previous levels to the midpoint. When the receiver stalls
// the output register holds its command, the input register takes one
// more word, and o_in_ready falls only when both are full.
// ============================================================================
module audio_waveform_span_plotter_core #(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 200,
    parameter int BASELINE_ROW  = 199
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Configuration write port.
    input  logic       i_cfg_wr_en,
    input  logic [1:0] i_cfg_idx,
    input  logic [1:0] i_cfg_data,
    // Sample channel.
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_channel,
    input  logic [7:0] i_sample,
    input  logic [8:0] i_position,
    input  logic       i_sweep_start,
    // Span command channel.
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_span_axis,
    output logic [8:0] o_fixed_coord,
    output logic [8:0] o_span_start,
    output logic [8:0] o_span_end,
    output logic [7:0] o_color_index
);
    import awsp_pkg::*;

    logic [1:0] r_plot_style;
    logic       r_orientation;
    logic [1:0] r_amp_shift;
    logic       r_out_vld;
    t_span      r_out;
    t_cfg       w_cfg;
    t_item      w_item;
    t_span      w_span;
    logic       w_s1_vld;
    logic       w_adv;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plot_style  <= RST_PLOT_STYLE;
            r_orientation <= RST_ORIENTATION;
            r_amp_shift   <= RST_AMP_SHIFT;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                REG_PLOT_STYLE:  r_plot_style  <= i_cfg_data;
                REG_ORIENTATION: r_orientation <= i_cfg_data[0];
                REG_AMP_SHIFT:   r_amp_shift   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_cfg.plot_style      = r_plot_style;
    assign w_cfg.orientation     = r_orientation;
    assign w_cfg.amplitude_shift = r_amp_shift;

    // The output register takes a new word when empty or being drained.
    assign w_adv = !r_out_vld || i_out_ready;

    awsp_in_stage u_in_stage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .i_channel    (i_channel),
        .i_sample     (i_sample),
        .i_position   (i_position),
        .i_sweep_start(i_sweep_start),
        .i_adv        (w_adv),
        .o_ready      (o_in_ready),
        .o_valid      (w_s1_vld),
        .o_item       (w_item)
    );

    awsp_span_calc #(
        .SCREEN_WIDTH (SCREEN_WIDTH),
        .SCREEN_HEIGHT(SCREEN_HEIGHT),
        .BASELINE_ROW (BASELINE_ROW)
    ) u_span_calc (
        .i_item(w_item),
        .i_cfg (w_cfg),
        .o_span(w_span)
    );

    // Output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= w_s1_vld;
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        if (w_adv && w_s1_vld) begin
            r_out <= w_span;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_span_axis   = r_out.span_axis;
    assign o_fixed_coord = r_out.fixed_coord;
    assign o_span_start  = r_out.span_start;
    assign o_span_end    = r_out.span_end;
    assign o_color_index = r_out.color_index;

endmodule

// ===== design/awsp_checker.sv =====
// ============================================================================
// awsp_checker
// Port-level checks for the waveform span plotter, bound to the top level.
// ============================================================================
`include "assert_macros.svh"

module awsp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [8:0] o_fixed_coord,
    input logic [8:0] o_span_start,
    input logic [8:0] o_span_end
);

    // A command never shows its ends out of order.
    `ASSERT_RST(a_span_order, i_clk, i_rst_n, o_out_valid |-> (o_span_start <= o_span_end), "span start above span end")

    // Reset flushes the output register.
    `ASSERT_ALWAYS(a_reset_flush, i_clk, !i_rst_n |=> !o_out_valid, "output word survived reset")

    // With an empty output register the pipeline can always take a word.
    `ASSERT_RST(a_ready_empty, i_clk, i_rst_n, !o_out_valid |-> o_in_ready, "not ready with empty output")

    // A stalled command holds its payload.
    `ASSERT_RST(a_stall_hold, i_clk, i_rst_n, (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_span_start) && $stable(o_span_end) && $stable(o_fixed_coord)), "stalled command changed")

endmodule

bind audio_waveform_span_plotter_core awsp_checker u_awsp_checker (.*);
